FILE: rtl/aroc_pkg.sv
//------------------------------------------------------------------------------
// aroc_pkg
// Shared types and codes of the accelerometer remap and offset calibration core.
//------------------------------------------------------------------------------
`default_nettype none

package aroc_pkg;

	// Field widths
	localparam int RAW_W  = 12;   // decoded axis
	localparam int AXIS_W = 13;   // remapped axis, load offset
	localparam int OUT_W  = 14;   // result axis, stored offset
	localparam int SUM_W  = 18;   // calibration sum
	localparam int ORI_W  = 3;

	// Command codes of an input beat
	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_CAL    = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;
	localparam logic [1:0] CMD_LOAD   = 2'd3;

	// Kind codes of a result beat
	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_CALIB  = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;
	localparam logic [1:0] KIND_OFFSET = 2'd3;

	// Mounting orientations
	localparam logic [ORI_W-1:0] MNT_NEG_XY    = 3'd0;  // (-dx,-dy, dz)
	localparam logic [ORI_W-1:0] MNT_ROT_CCW   = 3'd1;  // (-dy, dx, dz)
	localparam logic [ORI_W-1:0] MNT_IDENT     = 3'd2;  // ( dx, dy, dz)
	localparam logic [ORI_W-1:0] MNT_ROT_CW    = 3'd3;  // ( dy,-dx, dz)
	localparam logic [ORI_W-1:0] MNT_FLIP_Y    = 3'd4;  // ( dx,-dy,-dz)
	localparam logic [ORI_W-1:0] MNT_SWAP      = 3'd5;  // ( dy, dx,-dz)
	localparam logic [ORI_W-1:0] MNT_FLIP_X    = 3'd6;  // (-dx, dy,-dz)
	localparam logic [ORI_W-1:0] MNT_SWAP_NEG  = 3'd7;  // (-dy,-dx,-dz)

	// Control broadcast from the top level to every axis lane
	typedef struct packed {
		logic       fire;       // input beat accepted
		logic [1:0] cmd;        // its command
		logic       acc;        // accumulate this beat
		logic       div_start;  // this beat ends a calibration run
		logic       div_fin;    // divider result is ready this cycle
	} lane_ctrl_t;

	// One result beat
	typedef struct packed {
		logic        [1:0]       kind;
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
		logic signed [OUT_W-1:0] z;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/aroc_if.sv
//------------------------------------------------------------------------------
// aroc_if
// Valid/ready channels of the core: raw input, result and configuration write.
//------------------------------------------------------------------------------
`default_nettype none

interface aroc_in_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                cmd;
	logic [7:0]                x_low_byte;
	logic [7:0]                x_high_byte;
	logic [7:0]                y_low_byte;
	logic [7:0]                y_high_byte;
	logic [7:0]                z_low_byte;
	logic [7:0]                z_high_byte;
	logic signed [12:0]        load_offset_x;
	logic signed [12:0]        load_offset_y;
	logic signed [12:0]        load_offset_z;

	modport source (
		output valid, cmd, x_low_byte, x_high_byte, y_low_byte, y_high_byte,
		       z_low_byte, z_high_byte, load_offset_x, load_offset_y, load_offset_z,
		input  ready
	);
	modport sink (
		input  valid, cmd, x_low_byte, x_high_byte, y_low_byte, y_high_byte,
		       z_low_byte, z_high_byte, load_offset_x, load_offset_y, load_offset_z,
		output ready
	);
endinterface

interface aroc_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic signed [13:0] axis_x;
	logic signed [13:0] axis_y;
	logic signed [13:0] axis_z;

	modport source (output valid, kind, axis_x, axis_y, axis_z, input ready);
	modport sink   (input  valid, kind, axis_x, axis_y, axis_z, output ready);
endinterface

interface aroc_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input  valid, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/aroc_remap.sv
//------------------------------------------------------------------------------
// aroc_remap
// Decode the three raw register pairs and rotate them by the mounting matrix.
//------------------------------------------------------------------------------
`default_nettype none

module aroc_remap (
	input  wire logic [7:0]                          x_lo,
	input  wire logic [7:0]                          x_hi,
	input  wire logic [7:0]                          y_lo,
	input  wire logic [7:0]                          y_hi,
	input  wire logic [7:0]                          z_lo,
	input  wire logic [7:0]                          z_hi,
	input  wire logic [aroc_pkg::ORI_W-1:0]          orient,
	output logic signed [aroc_pkg::AXIS_W-1:0]       rx,
	output logic signed [aroc_pkg::AXIS_W-1:0]       ry,
	output logic signed [aroc_pkg::AXIS_W-1:0]       rz
);

	logic signed [aroc_pkg::RAW_W-1:0]  dx_raw, dy_raw, dz_raw;
	logic signed [aroc_pkg::AXIS_W-1:0] dx, dy, dz;

	// High byte is signed, low nibble sits in bits 7..4 of the low byte
	assign dx_raw = $signed({x_hi, x_lo[7:4]});
	assign dy_raw = $signed({y_hi, y_lo[7:4]});
	assign dz_raw = $signed({z_hi, z_lo[7:4]});
	assign dx = aroc_pkg::AXIS_W'(dx_raw);
	assign dy = aroc_pkg::AXIS_W'(dy_raw);
	assign dz = aroc_pkg::AXIS_W'(dz_raw);

	// Select and negate per orientation
	always_comb begin
		unique case (orient)
			aroc_pkg::MNT_NEG_XY: begin
				rx = -dx; ry = -dy; rz = dz;
			end
			aroc_pkg::MNT_ROT_CCW: begin
				rx = -dy; ry = dx; rz = dz;
			end
			aroc_pkg::MNT_IDENT: begin
				rx = dx; ry = dy; rz = dz;
			end
			aroc_pkg::MNT_ROT_CW: begin
				rx = dy; ry = -dx; rz = dz;
			end
			aroc_pkg::MNT_FLIP_Y: begin
				rx = dx; ry = -dy; rz = -dz;
			end
			aroc_pkg::MNT_SWAP: begin
				rx = dy; ry = dx; rz = -dz;
			end
			aroc_pkg::MNT_FLIP_X: begin
				rx = -dx; ry = dy; rz = -dz;
			end
			aroc_pkg::MNT_SWAP_NEG: begin
				rx = -dy; ry = -dx; rz = -dz;
			end
			default: begin
				rx = dx; ry = dy; rz = dz;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/aroc_lane.sv
//------------------------------------------------------------------------------
// aroc_lane
// One axis: offset store, offset subtract, saturating calibration sum and a
// two-stage reciprocal divider that turns the sum into the new offset.
//------------------------------------------------------------------------------
`default_nettype none

module aroc_lane #(
	parameter int         CAL_SAMPLES = 20,
	parameter int         ONE_G       = 1024,
	parameter logic       AXIS_Z      = 1'b0
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire aroc_pkg::lane_ctrl_t                  ctrl,
	input  wire logic signed [aroc_pkg::AXIS_W-1:0]    sample,
	input  wire logic signed [aroc_pkg::AXIS_W-1:0]    load_val,
	output logic signed [aroc_pkg::OUT_W-1:0]          axis_now,
	output logic signed [aroc_pkg::OUT_W-1:0]          off_div
);

	localparam int SUM_W  = aroc_pkg::SUM_W;
	localparam int OUT_W  = aroc_pkg::OUT_W;
	localparam int WIDE_W = SUM_W + 1;
	localparam int SHIFT  = SUM_W + $clog2(CAL_SAMPLES);
	localparam int RCP_W  = SUM_W + 2;
	localparam int PROD_W = SUM_W + RCP_W;
	localparam logic [RCP_W-1:0] RECIP = RCP_W'(((longint'(1) << SHIFT)
		+ longint'(CAL_SAMPLES) - longint'(1)) / longint'(CAL_SAMPLES));
	localparam logic signed [WIDE_W-1:0] SUM_MAX = WIDE_W'((1 << (SUM_W - 1)) - 1);
	localparam logic signed [WIDE_W-1:0] SUM_MIN = -WIDE_W'(1 << (SUM_W - 1));
	localparam logic signed [WIDE_W-1:0] GRAV    = AXIS_Z ? WIDE_W'(ONE_G) : '0;
	localparam logic signed [WIDE_W-1:0] ZLIM_HI = WIDE_W'(2047);
	localparam logic signed [WIDE_W-1:0] ZLIM_LO = -WIDE_W'(2048);
	localparam logic signed [OUT_W-1:0]  LD_HI   = AXIS_Z ? OUT_W'(2047) : OUT_W'(2048);
	localparam logic signed [OUT_W-1:0]  LD_LO   = -OUT_W'(2048);

	logic signed [OUT_W-1:0]  off_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [WIDE_W-1:0] sum_wide;
	logic signed [SUM_W-1:0]  sum_sat;
	logic [SUM_W-1:0]         mag;
	logic [SUM_W-1:0]         mag_s1;
	logic                     neg_s1;
	logic [PROD_W-1:0]        prod_s2;
	logic                     neg_s2;
	logic [SUM_W-1:0]         q_mag;
	logic signed [WIDE_W-1:0] q_s, q_adj, q_fin;
	logic signed [OUT_W-1:0]  sample_w, load_w, load_c;

	// Saturating accumulate
	assign sum_wide = WIDE_W'(sum_q) + WIDE_W'(sample);
	always_comb begin
		if (sum_wide > SUM_MAX) begin
			sum_sat = SUM_W'(SUM_MAX);
		end else if (sum_wide < SUM_MIN) begin
			sum_sat = SUM_W'(SUM_MIN);
		end else begin
			sum_sat = SUM_W'(sum_wide);
		end
	end

	// Magnitude for the unsigned divider, sign travels alongside
	assign mag = sum_sat[SUM_W-1] ? (~sum_sat + 1'b1) : sum_sat;

	// Hold sum; clear it when a run ends or is discarded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctrl.div_start) begin
			sum_q <= '0;
		end else if (ctrl.acc) begin
			sum_q <= sum_sat;
		end else if (ctrl.fire && (ctrl.cmd == aroc_pkg::CMD_CLEAR ||
		                           ctrl.cmd == aroc_pkg::CMD_LOAD)) begin
			sum_q <= '0;
		end
	end

	// Divider stage 1: capture magnitude and sign
	always_ff @(posedge clk) begin
		if (ctrl.div_start) begin
			mag_s1 <= mag;
			neg_s1 <= sum_sat[SUM_W-1];
		end
	end

	// Divider stage 2: multiply by the reciprocal
	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(mag_s1) * PROD_W'(RECIP);
		neg_s2  <= neg_s1;
	end

	// Shift down, restore sign, move Z one g toward zero and clamp it
	assign q_mag = SUM_W'(prod_s2 >> SHIFT);
	assign q_s   = neg_s2 ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
	always_comb begin
		if (q_s > 0) begin
			q_adj = q_s - GRAV;
		end else if (q_s < 0) begin
			q_adj = q_s + GRAV;
		end else begin
			q_adj = q_s;
		end
		q_fin = q_adj;
		if (AXIS_Z) begin
			if (q_adj > ZLIM_HI) begin
				q_fin = ZLIM_HI;
			end else if (q_adj < ZLIM_LO) begin
				q_fin = ZLIM_LO;
			end
		end
	end
	assign off_div = OUT_W'(q_fin);

	// Clamp a loaded offset
	assign load_w = OUT_W'(load_val);
	always_comb begin
		if (load_w > LD_HI) begin
			load_c = LD_HI;
		end else if (load_w < LD_LO) begin
			load_c = LD_LO;
		end else begin
			load_c = load_w;
		end
	end

	// Offset register, kept modulo the result width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
		end else if (ctrl.div_fin) begin
			off_q <= off_div;
		end else if (ctrl.fire && ctrl.cmd == aroc_pkg::CMD_CLEAR) begin
			off_q <= '0;
		end else if (ctrl.fire && ctrl.cmd == aroc_pkg::CMD_LOAD) begin
			off_q <= load_c;
		end
	end

	// Immediate result of this axis
	assign sample_w = OUT_W'(sample);
	always_comb begin
		case (ctrl.cmd)
			aroc_pkg::CMD_SAMPLE: axis_now = sample_w - off_q;
			aroc_pkg::CMD_CAL:    axis_now = sample_w;
			aroc_pkg::CMD_CLEAR:  axis_now = '0;
			default:              axis_now = load_c;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/aroc_merge.sv
//------------------------------------------------------------------------------
// aroc_merge
// Combine the lane values with the kind code and queue them in a two-entry
// output buffer that drives the result channel.
//------------------------------------------------------------------------------
`default_nettype none

module aroc_merge (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                push,
	input  wire logic [1:0]                          kind,
	input  wire logic signed [aroc_pkg::OUT_W-1:0]   vx,
	input  wire logic signed [aroc_pkg::OUT_W-1:0]   vy,
	input  wire logic signed [aroc_pkg::OUT_W-1:0]   vz,
	output logic                                     full,
	aroc_out_if.source                               out_ch
);

	aroc_pkg::result_t slot_q [2];
	logic              wr_q, rd_q;
	logic [1:0]        cnt_q;
	logic              pop;

	assign pop          = out_ch.valid && out_ch.ready;
	assign full         = (cnt_q == 2'd2);
	assign out_ch.valid = (cnt_q != 2'd0);
	assign out_ch.kind   = slot_q[rd_q].kind;
	assign out_ch.axis_x = slot_q[rd_q].x;
	assign out_ch.axis_y = slot_q[rd_q].y;
	assign out_ch.axis_z = slot_q[rd_q].z;

	// Write the merged beat
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= '{kind: kind, x: vx, y: vy, z: vz};
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/accel_axis_remap_offset_calibrate_core.sv
//------------------------------------------------------------------------------
// accel_axis_remap_offset_calibrate_core
// Accelerometer axis remap with offset subtraction and averaging calibration.
//------------------------------------------------------------------------------
// Usage:
//  in_ch carries one command beat: six raw register bytes plus load offsets.
//  out_ch returns exactly one result beat per input beat, in order.
//  cfg_ch writes the mounting orientation; it is always ready and must only
//  be written while no beat is in flight.
//  Throughput: one beat per cycle while in_ch.ready is high. The beat that
//  completes a calibration run goes through a two-stage reciprocal multiply
//  in each axis lane; input is held after it until the offsets are written,
//  so the next beat sees the new offsets. Results are registered in the
//  output buffer; a run-completing beat first passes both divider stages.
//  A two-entry output buffer lets input continue while a result waits; when
//  the receiver stalls and the buffer fills, in_ch.ready drops.
//  Reset clears offsets, sums and the sample count and sets the orientation
//  to identity mounting.
//------------------------------------------------------------------------------
`default_nettype none

module accel_axis_remap_offset_calibrate_core #(
	parameter int CAL_SAMPLES = 20,
	parameter int ONE_G       = 1024
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	aroc_in_if.sink    in_ch,
	aroc_out_if.source out_ch,
	aroc_cfg_if.sink   cfg_ch
);

	localparam int CNT_W = $clog2(CAL_SAMPLES + 1);

	logic [aroc_pkg::ORI_W-1:0]         orient_q;
	logic [CNT_W-1:0]                   count_q, count_inc;
	logic                               busy_q;
	logic                               div_s1, div_s2;
	logic                               fire, acc, done, full, push;
	logic [1:0]                         kind;
	aroc_pkg::lane_ctrl_t               ctrl;
	logic signed [aroc_pkg::AXIS_W-1:0] rx, ry, rz;
	logic signed [aroc_pkg::OUT_W-1:0]  nx, ny, nz, dx, dy, dz;
	logic signed [aroc_pkg::OUT_W-1:0]  vx, vy, vz;

	// Configuration register
	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orient_q <= aroc_pkg::MNT_IDENT;
		end else if (cfg_ch.valid) begin
			orient_q <= cfg_ch.data;
		end
	end

	// Input handshake and calibration run control
	assign in_ch.ready = !busy_q && !full;
	assign fire        = in_ch.valid && in_ch.ready;
	assign acc         = fire && (in_ch.cmd == aroc_pkg::CMD_CAL);
	assign count_inc   = count_q + 1'b1;
	assign done        = acc && (count_inc >= CNT_W'(CAL_SAMPLES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (done) begin
			count_q <= '0;
		end else if (acc) begin
			count_q <= count_inc;
		end else if (fire && (in_ch.cmd == aroc_pkg::CMD_CLEAR ||
		                      in_ch.cmd == aroc_pkg::CMD_LOAD)) begin
			count_q <= '0;
		end
	end

	// Track the divider stages; hold input until the offsets are written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_s1 <= 1'b0;
			div_s2 <= 1'b0;
			busy_q <= 1'b0;
		end else begin
			div_s1 <= done;
			div_s2 <= div_s1;
			busy_q <= done || div_s1;
		end
	end

	assign ctrl = '{fire: fire, cmd: in_ch.cmd, acc: acc, div_start: done, div_fin: div_s2};

	aroc_remap u_remap (
		.x_lo   (in_ch.x_low_byte),
		.x_hi   (in_ch.x_high_byte),
		.y_lo   (in_ch.y_low_byte),
		.y_hi   (in_ch.y_high_byte),
		.z_lo   (in_ch.z_low_byte),
		.z_hi   (in_ch.z_high_byte),
		.orient (orient_q),
		.rx     (rx),
		.ry     (ry),
		.rz     (rz)
	);

	aroc_lane #(.CAL_SAMPLES(CAL_SAMPLES), .ONE_G(ONE_G), .AXIS_Z(1'b0)) u_lane_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.sample   (rx),
		.load_val (in_ch.load_offset_x),
		.axis_now (nx),
		.off_div  (dx)
	);

	aroc_lane #(.CAL_SAMPLES(CAL_SAMPLES), .ONE_G(ONE_G), .AXIS_Z(1'b0)) u_lane_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.sample   (ry),
		.load_val (in_ch.load_offset_y),
		.axis_now (ny),
		.off_div  (dy)
	);

	aroc_lane #(.CAL_SAMPLES(CAL_SAMPLES), .ONE_G(ONE_G), .AXIS_Z(1'b1)) u_lane_z (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.sample   (rz),
		.load_val (in_ch.load_offset_z),
		.axis_now (nz),
		.off_div  (dz)
	);

	// Pick the beat to push: divider result, or the immediate lane values
	always_comb begin
		case (in_ch.cmd)
			aroc_pkg::CMD_SAMPLE: kind = aroc_pkg::KIND_SAMPLE;
			aroc_pkg::CMD_CAL:    kind = aroc_pkg::KIND_CALIB;
			default:              kind = aroc_pkg::KIND_OFFSET;
		endcase
		if (div_s2) begin
			kind = aroc_pkg::KIND_DONE;
		end
	end
	assign push = div_s2 || (fire && !done);
	assign vx   = div_s2 ? dx : nx;
	assign vy   = div_s2 ? dy : ny;
	assign vz   = div_s2 ? dz : nz;

	aroc_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.kind   (kind),
		.vx     (vx),
		.vy     (vy),
		.vz     (vz),
		.full   (full),
		.out_ch (out_ch)
	);

endmodule

`default_nettype wire

FILE: verif/accel_axis_remap_offset_calibrate_core_tb.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// accel_axis_remap_offset_calibrate_core_tb
// Self-checking bench for the accelerometer remap and calibration core. A
// queue-fed driver sends raw register beats in bursts while the result side
// stalls on its own pattern. Every accepted beat runs through an in-bench
// model of the decode, remap, offset and averaging logic, and each result
// beat is compared field by field with the oldest prediction. The run walks
// through every mounting orientation, with calibration runs, offset loads
// and clears mixed into random traffic.
//------------------------------------------------------------------------------
`default_nettype none

module accel_axis_remap_offset_calibrate_core_tb;

	localparam int CAL_SAMPLES   = 20;
	localparam int ONE_G         = 1024;
	localparam int CLK_HALF      = 6;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_BEATS   = 50;
	localparam int SUM_MAX       = 131071;
	localparam int SUM_MIN       = -131072;

	// One raw input beat
	typedef struct {
		logic        [1:0]  cmd;
		logic        [7:0]  xl, xh, yl, yh, zl, zh;
		logic signed [12:0] lx, ly, lz;
	} raw_beat_t;

	logic clk;
	logic arst_n;

	aroc_in_if  in_ch ();
	aroc_out_if out_ch ();
	aroc_cfg_if cfg_ch ();

	accel_axis_remap_offset_calibrate_core #(
		.CAL_SAMPLES (CAL_SAMPLES),
		.ONE_G       (ONE_G)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	// Stimulus and prediction state
	raw_beat_t           raw_items [$];
	aroc_pkg::result_t   expected_axes [$];
	int                  beats_queued;
	int                  beats_accepted;
	int                  cfg_writes;
	int                  mismatches;
	bit                  in_taken;

	logic [aroc_pkg::ORI_W-1:0] mount;
	int                         ofs_x, ofs_y, ofs_z;
	int                         acc_x, acc_y, acc_z;
	int                         cal_count;

	int burst_left;
	int gap_left;
	int rx_cycle;
	int rx_mode;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Decode one axis: signed high byte weighs 16, low byte nibble 7..4 below it
	function automatic int axis_value(input logic [7:0] lo, input logic [7:0] hi);
		int top;
		int nib;
		top = int'($signed(hi));
		nib = int'(lo[7:4]);
		return top * 16 + nib;
	endfunction

	function automatic int clip(input int v, input int lo, input int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Advance the offset and calibration state by one beat, queue its result
	task automatic predict_axes(input raw_beat_t b);
		int dx, dy, dz;
		int rx, ry, rz;
		int ox, oy, oz;
		int avg_z;
		aroc_pkg::result_t want;

		dx = axis_value(b.xl, b.xh);
		dy = axis_value(b.yl, b.yh);
		dz = axis_value(b.zl, b.zh);
		case (mount)
			aroc_pkg::MNT_NEG_XY:  begin rx = -dx; ry = -dy; rz =  dz; end
			aroc_pkg::MNT_ROT_CCW: begin rx = -dy; ry =  dx; rz =  dz; end
			aroc_pkg::MNT_IDENT:   begin rx =  dx; ry =  dy; rz =  dz; end
			aroc_pkg::MNT_ROT_CW:  begin rx =  dy; ry = -dx; rz =  dz; end
			aroc_pkg::MNT_FLIP_Y:  begin rx =  dx; ry = -dy; rz = -dz; end
			aroc_pkg::MNT_SWAP:    begin rx =  dy; ry =  dx; rz = -dz; end
			aroc_pkg::MNT_FLIP_X:  begin rx = -dx; ry =  dy; rz = -dz; end
			default:               begin rx = -dy; ry = -dx; rz = -dz; end
		endcase

		case (b.cmd)
			aroc_pkg::CMD_SAMPLE: begin
				want.kind = aroc_pkg::KIND_SAMPLE;
				ox = rx - ofs_x;
				oy = ry - ofs_y;
				oz = rz - ofs_z;
			end
			aroc_pkg::CMD_CAL: begin
				acc_x = clip(acc_x + rx, SUM_MIN, SUM_MAX);
				acc_y = clip(acc_y + ry, SUM_MIN, SUM_MAX);
				acc_z = clip(acc_z + rz, SUM_MIN, SUM_MAX);
				cal_count++;
				if (cal_count >= CAL_SAMPLES) begin
					// Average toward zero, then pull Z one g toward zero
					ofs_x = acc_x / CAL_SAMPLES;
					ofs_y = acc_y / CAL_SAMPLES;
					avg_z = acc_z / CAL_SAMPLES;
					if (avg_z > 0)
						avg_z -= ONE_G;
					else if (avg_z < 0)
						avg_z += ONE_G;
					ofs_z = clip(avg_z, -2048, 2047);
					acc_x = 0; acc_y = 0; acc_z = 0; cal_count = 0;
					want.kind = aroc_pkg::KIND_DONE;
					ox = ofs_x; oy = ofs_y; oz = ofs_z;
				end else begin
					want.kind = aroc_pkg::KIND_CALIB;
					ox = rx; oy = ry; oz = rz;
				end
			end
			default: begin
				if (b.cmd == aroc_pkg::CMD_CLEAR) begin
					ofs_x = 0; ofs_y = 0; ofs_z = 0;
				end else begin
					ofs_x = clip(int'(b.lx), -2048, 2048);
					ofs_y = clip(int'(b.ly), -2048, 2048);
					ofs_z = clip(int'(b.lz), -2048, 2047);
				end
				// Drop any partial calibration run
				acc_x = 0; acc_y = 0; acc_z = 0; cal_count = 0;
				want.kind = aroc_pkg::KIND_OFFSET;
				ox = ofs_x; oy = ofs_y; oz = ofs_z;
			end
		endcase

		want.x = ox[aroc_pkg::OUT_W-1:0];
		want.y = oy[aroc_pkg::OUT_W-1:0];
		want.z = oz[aroc_pkg::OUT_W-1:0];
		expected_axes.push_back(want);
	endtask

	function automatic raw_beat_t make_beat(
		input logic [1:0] cmd,
		input logic [7:0] xl, input logic [7:0] xh,
		input logic [7:0] yl, input logic [7:0] yh,
		input logic [7:0] zl, input logic [7:0] zh,
		input logic signed [12:0] lx, input logic signed [12:0] ly,
		input logic signed [12:0] lz
	);
		raw_beat_t b;
		b.cmd = cmd;
		b.xl = xl; b.xh = xh; b.yl = yl; b.yh = yh; b.zl = zl; b.zh = zh;
		b.lx = lx; b.ly = ly; b.lz = lz;
		return b;
	endfunction

	function automatic logic [7:0] random_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// Half in range, half anywhere in 13 bits so clamping gets exercised
	function automatic logic signed [12:0] random_offset();
		if ($urandom_range(0, 1) == 0)
			return 13'($urandom_range(0, 4096) - 2048);
		return 13'($urandom_range(0, 8191));
	endfunction

	function automatic raw_beat_t random_beat(input logic [1:0] cmd);
		return make_beat(cmd,
			random_byte(), random_byte(),
			random_byte(), random_byte(),
			random_byte(), random_byte(),
			random_offset(), random_offset(), random_offset());
	endfunction

	task automatic queue_beat(input raw_beat_t b);
		raw_items.push_back(b);
		beats_queued++;
	endtask

	// Full calibration run with stray samples mixed in; now and then cut short
	task automatic queue_cal_run();
		bit broken;
		int cut_at;
		logic [1:0] cut_cmd;
		broken  = ($urandom_range(0, 7) == 0);
		cut_at  = $urandom_range(1, CAL_SAMPLES - 1);
		cut_cmd = ($urandom_range(0, 1) == 0) ? aroc_pkg::CMD_CLEAR : aroc_pkg::CMD_LOAD;
		for (int i = 0; i < CAL_SAMPLES; i++) begin
			if (broken && i == cut_at) begin
				queue_beat(random_beat(cut_cmd));
				return;
			end
			if ($urandom_range(0, 5) == 0)
				queue_beat(random_beat(aroc_pkg::CMD_SAMPLE));
			queue_beat(random_beat(aroc_pkg::CMD_CAL));
		end
	endtask

	task automatic queue_mixed_phase(input int count);
		int target;
		logic [1:0] cmd;
		target = beats_queued + count;
		while (beats_queued < target) begin
			if ($urandom_range(0, 9) < 5) begin
				queue_cal_run();
			end else begin
				cmd = 2'($urandom_range(0, 3));
				queue_beat(random_beat(cmd));
			end
		end
	endtask

	// Hold until every beat is accepted and answered, then let the pipe drain
	task automatic wait_idle();
		while (beats_accepted != beats_queued || expected_axes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mount(input logic [aroc_pkg::ORI_W-1:0] m);
		int target;
		target = cfg_writes + 1;
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= m;
		while (cfg_writes != target)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Reset, directed beats, then one random phase per mounting orientation
	initial begin
		logic [aroc_pkg::ORI_W-1:0] mount_order [8];
		mount_order[0] = aroc_pkg::MNT_NEG_XY;
		mount_order[1] = aroc_pkg::MNT_SWAP_NEG;
		mount_order[2] = aroc_pkg::MNT_ROT_CCW;
		mount_order[3] = aroc_pkg::MNT_ROT_CW;
		mount_order[4] = aroc_pkg::MNT_FLIP_Y;
		mount_order[5] = aroc_pkg::MNT_SWAP;
		mount_order[6] = aroc_pkg::MNT_FLIP_X;
		mount_order[7] = aroc_pkg::MNT_IDENT;

		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.cmd = aroc_pkg::CMD_SAMPLE;
		in_ch.x_low_byte = '0;
		in_ch.x_high_byte = '0;
		in_ch.y_low_byte = '0;
		in_ch.y_high_byte = '0;
		in_ch.z_low_byte = '0;
		in_ch.z_high_byte = '0;
		in_ch.load_offset_x = '0;
		in_ch.load_offset_y = '0;
		in_ch.load_offset_z = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		beats_queued = 0;
		beats_accepted = 0;
		cfg_writes = 0;
		mismatches = 0;
		in_taken = 1'b0;
		mount = aroc_pkg::MNT_IDENT;
		ofs_x = 0; ofs_y = 0; ofs_z = 0;
		acc_x = 0; acc_y = 0; acc_z = 0;
		cal_count = 0;
		burst_left = 1;
		gap_left = 0;
		rx_cycle = 0;
		rx_mode = 0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Loads past both clamp limits, including the narrower Z limit
		queue_beat(make_beat(aroc_pkg::CMD_LOAD,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
			13'sd4095, -13'sd4096, 13'sd2048));
		queue_beat(make_beat(aroc_pkg::CMD_LOAD,
			8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
			-13'sd2049, 13'sd2049, -13'sd4096));
		// Raw byte extremes
		queue_beat(make_beat(aroc_pkg::CMD_SAMPLE,
			8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
			13'sd0, 13'sd0, 13'sd0));
		queue_beat(make_beat(aroc_pkg::CMD_SAMPLE,
			8'h0f, 8'h80, 8'hf0, 8'h7f, 8'hf0, 8'h80,
			13'sd0, 13'sd0, 13'sd0));
		queue_beat(make_beat(aroc_pkg::CMD_CLEAR,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
			13'sd0, 13'sd0, 13'sd0));
		// Sample inside a run keeps it, then a load throws it away
		queue_beat(random_beat(aroc_pkg::CMD_CAL));
		queue_beat(random_beat(aroc_pkg::CMD_SAMPLE));
		queue_beat(random_beat(aroc_pkg::CMD_LOAD));
		// Full run with Z at exactly zero, then a sample with the new offsets
		for (int i = 0; i < CAL_SAMPLES; i++)
			queue_beat(make_beat(aroc_pkg::CMD_CAL,
				random_byte(), random_byte(),
				random_byte(), random_byte(),
				8'($urandom_range(0, 15)), 8'h00, 13'sd0, 13'sd0, 13'sd0));
		queue_beat(random_beat(aroc_pkg::CMD_SAMPLE));
		wait_idle();

		for (int p = 0; p < 8; p++) begin
			write_mount(mount_order[p]);
			queue_mixed_phase(PHASE_BEATS);
			wait_idle();
		end

		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Drive raw beats in bursts with random gaps; hold a beat until taken
	always @(negedge clk) begin : raw_driver
		raw_beat_t nxt;
		if (arst_n && !(in_ch.valid && !in_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_ch.valid <= 1'b0;
			end else if (raw_items.size() > 0) begin
				nxt = raw_items.pop_front();
				in_ch.valid         <= 1'b1;
				in_ch.cmd           <= nxt.cmd;
				in_ch.x_low_byte    <= nxt.xl;
				in_ch.x_high_byte   <= nxt.xh;
				in_ch.y_low_byte    <= nxt.yl;
				in_ch.y_high_byte   <= nxt.yh;
				in_ch.z_low_byte    <= nxt.zl;
				in_ch.z_high_byte   <= nxt.zh;
				in_ch.load_offset_x <= nxt.lx;
				in_ch.load_offset_y <= nxt.ly;
				in_ch.load_offset_z <= nxt.lz;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Stall results on a pattern that is picked anew at random
	always @(negedge clk) begin : result_sink
		if (arst_n) begin
			if (rx_cycle % 64 == 0)
				rx_mode = $urandom_range(0, 3);
			case (rx_mode)
				0:       out_ch.ready <= 1'b1;
				1:       out_ch.ready <= (rx_cycle % 2 == 0);
				2:       out_ch.ready <= ($urandom_range(0, 1) == 0);
				default: out_ch.ready <= (rx_cycle % 4 == 0);
			endcase
			rx_cycle++;
		end
	end

	// Check result beats, predict accepted raw beats, track config writes
	always @(posedge clk) begin : beat_monitor
		aroc_pkg::result_t want;
		raw_beat_t         got;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_axes.size() == 0) begin
					$error("result beat with no prediction waiting: kind %0d", out_ch.kind);
					mismatches++;
				end else begin
					want = expected_axes.pop_front();
					if (out_ch.kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, out_ch.kind);
						mismatches++;
					end
					if (out_ch.axis_x !== want.x) begin
						$error("axis_x: expected %0d, got %0d", want.x, out_ch.axis_x);
						mismatches++;
					end
					if (out_ch.axis_y !== want.y) begin
						$error("axis_y: expected %0d, got %0d", want.y, out_ch.axis_y);
						mismatches++;
					end
					if (out_ch.axis_z !== want.z) begin
						$error("axis_z: expected %0d, got %0d", want.z, out_ch.axis_z);
						mismatches++;
					end
				end
			end

			in_taken = in_ch.valid && in_ch.ready;
			if (in_taken) begin
				got.cmd = in_ch.cmd;
				got.xl = in_ch.x_low_byte;
				got.xh = in_ch.x_high_byte;
				got.yl = in_ch.y_low_byte;
				got.yh = in_ch.y_high_byte;
				got.zl = in_ch.z_low_byte;
				got.zh = in_ch.z_high_byte;
				got.lx = in_ch.load_offset_x;
				got.ly = in_ch.load_offset_y;
				got.lz = in_ch.load_offset_z;
				predict_axes(got);
				beats_accepted++;
			end

			if (cfg_ch.valid && cfg_ch.ready) begin
				mount = cfg_ch.data;
				cfg_writes++;
			end
		end
	end

	// Bound the run
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
